// ===== rtl/prd_pkg.sv =====
// shared types and constants of the pulse rate detector
package prd_pkg;

  localparam int WINDOW_DEPTH = 32;
  localparam int WIN_AW       = $clog2(WINDOW_DEPTH);

  localparam int SAMPLE_W   = 12;
  localparam int PERIOD_W   = 10;
  localparam int TICK_W     = 16;
  localparam int SPIKE_W    = 11;
  localparam int BPM_W      = 8;
  localparam int INTERVAL_W = 26;
  localparam int DIVIDEND_W = 16;
  localparam int DIV_CNT_W  = $clog2(DIVIDEND_W);

  localparam logic [DIVIDEND_W-1:0] BPM_NUMERATOR = 16'd60000;
  localparam logic [BPM_W-1:0]      BPM_MAX       = 8'd200;
  localparam logic [BPM_W-1:0]      BPM_MIN       = 8'd30;
  localparam logic [SPIKE_W-1:0]    SPIKE_RESET   = 11'd1024;
  localparam logic [PERIOD_W-1:0]   PERIOD_RESET  = 10'd40;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SCAN_WAIT,
    ST_THRESH,
    ST_CMP,
    ST_DIV,
    ST_DIV_WAIT,
    ST_DONE
  } prd_state_t;

  typedef struct packed {
    logic                  start;
    logic [INTERVAL_W-1:0] divisor;
  } prd_div_req_t;

  typedef struct packed {
    logic                  done;
    logic [DIVIDEND_W-1:0] quotient;
  } prd_div_rsp_t;

endpackage

// ===== rtl/prd_if.sv =====
// sample and result channel interfaces
interface prd_in_if
  import prd_pkg::*;
  ();
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface prd_out_if
  import prd_pkg::*;
  ();
  logic                  valid;
  logic                  ready;
  logic [BPM_W-1:0]      beats_per_minute;
  logic [INTERVAL_W-1:0] beat_interval_ms;

  modport source (output valid, output beats_per_minute, output beat_interval_ms, input ready);
  modport sink   (input valid, input beats_per_minute, input beat_interval_ms, output ready);
endinterface

// ===== rtl/pulse_rate_detector.sv =====
// pulse rate detector top level: window threshold tracking and beat timing
// An ordinary sample passes through the compare state and back to idle. A
// sample that fills the window first scans the window ram, one read per entry,
// waits for the last read and updates the threshold. A sample that closes a beat
// then runs the one-bit-per-cycle divider, unless the interval is zero, and waits
// for the result register to be taken. Ready is high only while the block is idle.
module pulse_rate_detector
  import prd_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  prd_in_if.sink              in_ch,
  prd_out_if.source           out_ch,
  input  logic                cfg_we,
  input  logic [PERIOD_W-1:0] cfg_data
);

  prd_state_t state_r, state_nxt;

  logic [PERIOD_W-1:0]   period_r;
  logic [WIN_AW-1:0]     wp_r, wp_nxt;
  logic [WIN_AW-1:0]     scan_idx_r, scan_idx_nxt;
  logic                  rd_vld_r, rd_first_r;
  logic [SAMPLE_W-1:0]   rdata;
  logic [SAMPLE_W-1:0]   hi_r, lo_r;
  logic [SAMPLE_W-1:0]   s_r, s_nxt;
  logic [SAMPLE_W-1:0]   last_r, last_nxt;
  logic [SAMPLE_W-1:0]   mid_r, mid_nxt;
  logic [SPIKE_W-1:0]    spike_r, spike_nxt;
  logic                  above_r, above_nxt;
  logic                  parity_r, parity_nxt;
  logic [TICK_W-1:0]     tick_r, tick_nxt;
  logic [TICK_W-1:0]     first_r, first_nxt;
  logic [INTERVAL_W-1:0] interval_r, interval_nxt;
  logic [BPM_W-1:0]      bpm_r, bpm_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [BPM_W-1:0]      out_bpm_r;
  logic [INTERVAL_W-1:0] out_int_r;

  logic                  in_xfer;
  logic                  store;
  logic                  win_full;
  logic                  above_now;
  logic                  rising;
  logic                  beat;
  logic                  out_free;
  logic signed [SAMPLE_W:0] rise;
  logic [SAMPLE_W:0]     thr_sum;
  logic [SAMPLE_W-1:0]   thr_diff;
  logic [TICK_W-1:0]     tick_diff;
  prd_div_req_t          div_req;
  prd_div_rsp_t          div_rsp;

  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_xfer     = in_ch.valid && in_ch.ready;
  assign rise        = signed'({1'b0, in_ch.sample}) - signed'({1'b0, last_r});
  assign store       = rise < signed'({2'b00, spike_r});
  assign win_full    = store && (wp_r == WIN_AW'(WINDOW_DEPTH - 1));
  assign above_now   = s_r > mid_r;
  assign rising      = !above_r && above_now;
  assign beat        = rising && parity_r && (first_r < tick_r);
  assign out_free    = !out_valid_r || out_ch.ready;
  assign thr_sum     = {1'b0, hi_r} + {1'b0, lo_r};
  assign thr_diff    = hi_r - lo_r;
  assign tick_diff   = tick_r - first_r;

  assign div_req.start   = (state_r == ST_DIV) && (interval_r != '0);
  assign div_req.divisor = interval_r;

  prd_ram #(
    .DEPTH (WINDOW_DEPTH),
    .WIDTH (SAMPLE_W)
  ) u_win (
    .clk   (clk),
    .we    (in_xfer && store),
    .waddr (wp_r),
    .wdata (in_ch.sample),
    .re    (state_r == ST_SCAN),
    .raddr (scan_idx_r),
    .rdata (rdata)
  );

  prd_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          state_nxt = win_full ? ST_SCAN : ST_CMP;
        end
      end
      ST_SCAN: begin
        if (scan_idx_r == WIN_AW'(WINDOW_DEPTH - 1)) begin
          state_nxt = ST_SCAN_WAIT;
        end
      end
      ST_SCAN_WAIT: state_nxt = ST_THRESH;
      ST_THRESH:    state_nxt = ST_CMP;
      ST_CMP:       state_nxt = beat ? ST_DIV : ST_IDLE;
      ST_DIV:       state_nxt = (interval_r == '0) ? ST_DONE : ST_DIV_WAIT;
      ST_DIV_WAIT: begin
        if (div_rsp.done) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // datapath updates
  always_comb begin
    wp_nxt        = wp_r;
    scan_idx_nxt  = scan_idx_r;
    s_nxt         = s_r;
    last_nxt      = last_r;
    mid_nxt       = mid_r;
    spike_nxt     = spike_r;
    above_nxt     = above_r;
    parity_nxt    = parity_r;
    tick_nxt      = tick_r;
    first_nxt     = first_r;
    interval_nxt  = interval_r;
    bpm_nxt       = bpm_r;
    out_valid_nxt = out_valid_r;
    if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      ST_IDLE: begin
        scan_idx_nxt = '0;
        if (in_xfer) begin
          s_nxt    = in_ch.sample;
          last_nxt = in_ch.sample;
          if (store) begin
            wp_nxt = win_full ? '0 : wp_r + 1'b1;
          end
        end
      end
      ST_SCAN: scan_idx_nxt = scan_idx_r + 1'b1;
      ST_THRESH: begin
        mid_nxt   = thr_sum[SAMPLE_W:1];
        spike_nxt = SPIKE_W'(thr_diff[SAMPLE_W-1:1]);
      end
      ST_CMP: begin
        above_nxt = above_now;
        tick_nxt  = tick_r + 1'b1;
        if (rising) begin
          parity_nxt = !parity_r;
          if (!parity_r) begin
            first_nxt = tick_r;
          end else begin
            tick_nxt     = TICK_W'(1);
            interval_nxt = INTERVAL_W'(tick_diff) * INTERVAL_W'(period_r);
          end
        end
      end
      ST_DIV: begin
        if (interval_r == '0) begin
          bpm_nxt = BPM_MAX;
        end
      end
      ST_DIV_WAIT: begin
        if (div_rsp.done) begin
          if (div_rsp.quotient > DIVIDEND_W'(BPM_MAX)) begin
            bpm_nxt = BPM_MAX;
          end else if (div_rsp.quotient < DIVIDEND_W'(BPM_MIN)) begin
            bpm_nxt = BPM_MIN;
          end else begin
            bpm_nxt = BPM_W'(div_rsp.quotient);
          end
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      period_r    <= PERIOD_RESET;
      wp_r        <= '0;
      last_r      <= '0;
      mid_r       <= '0;
      spike_r     <= SPIKE_RESET;
      above_r     <= 1'b0;
      parity_r    <= 1'b0;
      tick_r      <= '0;
      first_r     <= '0;
      out_valid_r <= 1'b0;
      rd_vld_r    <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      if (cfg_we) begin
        period_r <= cfg_data;
      end
      wp_r        <= wp_nxt;
      last_r      <= last_nxt;
      mid_r       <= mid_nxt;
      spike_r     <= spike_nxt;
      above_r     <= above_nxt;
      parity_r    <= parity_nxt;
      tick_r      <= tick_nxt;
      first_r     <= first_nxt;
      out_valid_r <= out_valid_nxt;
      rd_vld_r    <= (state_r == ST_SCAN);
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    scan_idx_r <= scan_idx_nxt;
    s_r        <= s_nxt;
    interval_r <= interval_nxt;
    bpm_r      <= bpm_nxt;
    rd_first_r <= (state_r == ST_SCAN) && (scan_idx_r == '0);
    if (rd_vld_r) begin
      if (rd_first_r) begin
        hi_r <= rdata;
        lo_r <= rdata;
      end else begin
        if (rdata > hi_r) hi_r <= rdata;
        if (rdata < lo_r) lo_r <= rdata;
      end
    end
    if ((state_r == ST_DONE) && out_free) begin
      out_bpm_r <= bpm_r;
      out_int_r <= interval_r;
    end
  end

  assign out_ch.valid            = out_valid_r;
  assign out_ch.beats_per_minute = out_bpm_r;
  assign out_ch.beat_interval_ms = out_int_r;

endmodule

// ===== rtl/prd_ram.sv =====
// generic single write port ram with registered read
module prd_ram #(
  parameter int DEPTH = 32,
  parameter int WIDTH = 12
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/prd_div.sv =====
// restoring divider for the rate numerator, one quotient bit per cycle
module prd_div
  import prd_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  prd_div_req_t req,
  output prd_div_rsp_t rsp
);

  logic                  busy_r;
  logic                  done_r;
  logic [DIV_CNT_W-1:0]  cnt_r;
  logic [INTERVAL_W-1:0] rem_r;
  logic [INTERVAL_W-1:0] div_r;
  logic [DIVIDEND_W-1:0] dq_r;
  logic [INTERVAL_W:0]   trial;
  logic                  fits;

  assign trial = {rem_r, dq_r[DIVIDEND_W-1]};
  assign fits  = trial >= {1'b0, div_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= DIV_CNT_W'(DIVIDEND_W - 1);
        rem_r  <= '0;
        div_r  <= req.divisor;
        dq_r   <= BPM_NUMERATOR;
      end else if (busy_r) begin
        rem_r <= fits ? INTERVAL_W'(trial - {1'b0, div_r}) : INTERVAL_W'(trial);
        dq_r  <= {dq_r[DIVIDEND_W-2:0], fits};
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = dq_r;

endmodule

// ===== tb/pulse_rate_detector_test.sv =====
// testbench of the pulse rate detector: directed script, random pulse trains, beat predictor
`timescale 1ns / 1ps

module pulse_rate_detector_test;
  import prd_pkg::*;

  localparam int RANDOM_ITEMS    = 1170;
  localparam int PHASE_ITEMS     = 210;
  localparam int SETTLE_CYCLES   = 64;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int DRAIN_LIMIT     = 20000;
  localparam int REPORT_LIMIT    = 10;
  localparam int TIMEOUT_NS      = 6000000;
  localparam int SCRIPT_LEN      = 24;

  typedef struct packed {
    logic [BPM_W-1:0]      bpm;
    logic [INTERVAL_W-1:0] interval;
  } beat_t;

  typedef enum logic {ROW_SAMPLE, ROW_PERIOD} row_kind_t;

  typedef struct packed {
    row_kind_t             kind;
    logic [SAMPLE_W-1:0]   value;
    logic [16:0]           count;
    logic                  typed;
    beat_t                 beat;
  } script_row_t;

  logic                clk;
  logic                rst_n;
  logic                cfg_we;
  logic [PERIOD_W-1:0] cfg_data;

  prd_in_if  in_ch ();
  prd_out_if out_ch ();

  pulse_rate_detector DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data)
  );

  // beat tracker state
  logic [SAMPLE_W-1:0] sample_window [WINDOW_DEPTH];
  int unsigned         fill_pos        = 0;
  logic [SAMPLE_W-1:0] prev_sample     = '0;
  logic [SAMPLE_W-1:0] threshold       = '0;
  logic [SPIKE_W-1:0]  spike_lim       = SPIKE_RESET;
  bit                  above           = 1'b0;
  bit                  odd_crossing    = 1'b0;
  logic [TICK_W-1:0]   ticks           = '0;
  logic [TICK_W-1:0]   pair_start_tick = '0;
  logic [PERIOD_W-1:0] period_ms       = PERIOD_RESET;

  beat_t beats_due [$];
  int    error_count  = 0;
  int    samples_sent = 0;
  bit    gaps_on      = 1'b0;
  bit    hold_off_due = 1'b0;

  script_row_t script [SCRIPT_LEN] = '{
    '{ROW_SAMPLE, 12'd0,    17'd1,     1'b0, '{8'd0,   26'd0}},
    '{ROW_SAMPLE, 12'd4095, 17'd1,     1'b0, '{8'd0,   26'd0}},
    '{ROW_SAMPLE, 12'd0,    17'd1,     1'b0, '{8'd0,   26'd0}},
    '{ROW_SAMPLE, 12'd1,    17'd1,     1'b1, '{8'd200, 26'd80}},
    '{ROW_PERIOD, 12'd1023, 17'd0,     1'b0, '{8'd0,   26'd0}},
    '{ROW_SAMPLE, 12'd0,    17'd1,     1'b0, '{8'd0,   26'd0}},
    '{ROW_SAMPLE, 12'd1,    17'd1,     1'b0, '{8'd0,   26'd0}},
    '{ROW_SAMPLE, 12'd0,    17'd1,     1'b0, '{8'd0,   26'd0}},
    '{ROW_SAMPLE, 12'd2,    17'd1,     1'b1, '{8'd30,  26'd2046}},
    '{ROW_PERIOD, 12'd0,    17'd0,     1'b0, '{8'd0,   26'd0}},
    '{ROW_SAMPLE, 12'd0,    17'd1,     1'b0, '{8'd0,   26'd0}},
    '{ROW_SAMPLE, 12'd5,    17'd1,     1'b0, '{8'd0,   26'd0}},
    '{ROW_SAMPLE, 12'd0,    17'd1,     1'b0, '{8'd0,   26'd0}},
    '{ROW_SAMPLE, 12'd5,    17'd1,     1'b1, '{8'd200, 26'd0}},
    '{ROW_PERIOD, 12'd1000, 17'd0,     1'b0, '{8'd0,   26'd0}},
    '{ROW_SAMPLE, 12'd0,    17'd1,     1'b0, '{8'd0,   26'd0}},
    '{ROW_SAMPLE, 12'd1024, 17'd1,     1'b0, '{8'd0,   26'd0}},
    '{ROW_SAMPLE, 12'd0,    17'd60,    1'b0, '{8'd0,   26'd0}},
    '{ROW_SAMPLE, 12'd4095, 17'd1,     1'b0, '{8'd0,   26'd0}},
    '{ROW_PERIOD, 12'd1,    17'd0,     1'b0, '{8'd0,   26'd0}},
    '{ROW_SAMPLE, 12'd0,    17'd1,     1'b0, '{8'd0,   26'd0}},
    '{ROW_SAMPLE, 12'd4095, 17'd1,     1'b0, '{8'd0,   26'd0}},
    '{ROW_SAMPLE, 12'd0,    17'd1,     1'b0, '{8'd0,   26'd0}},
    '{ROW_SAMPLE, 12'd4095, 17'd1,     1'b0, '{8'd0,   26'd0}}
  };

  function automatic bit track_beat(input logic [SAMPLE_W-1:0] s, output beat_t b);
    int                  rise;
    bit                  was_above;
    bit                  produced;
    logic [SAMPLE_W-1:0] hi;
    logic [SAMPLE_W-1:0] lo;
    logic [TICK_W-1:0]   end_tick;
    logic [31:0]         interval;
    logic [31:0]         bpm;
    rise = int'(s) - int'(prev_sample);
    was_above = above;
    produced = 1'b0;
    b = '0;
    prev_sample = s;
    if (rise < int'(spike_lim)) begin
      if (fill_pos < WINDOW_DEPTH) sample_window[fill_pos] = s;
      fill_pos++;
    end
    if (fill_pos >= WINDOW_DEPTH) begin
      fill_pos = 0;
      hi = sample_window[0];
      lo = sample_window[0];
      for (int k = 1; k < WINDOW_DEPTH; k++) begin
        if (sample_window[k] > hi) hi = sample_window[k];
        if (sample_window[k] < lo) lo = sample_window[k];
      end
      threshold = SAMPLE_W'((int'(hi) + int'(lo)) / 2);
      spike_lim = SPIKE_W'((int'(hi) - int'(lo)) / 2);
    end
    above = (s > threshold);
    if (!was_above && above) begin
      odd_crossing = !odd_crossing;
      if (odd_crossing) begin
        pair_start_tick = ticks;
      end else begin
        end_tick = ticks;
        ticks = '0;
        if (pair_start_tick < end_tick) begin
          interval = 32'(end_tick - pair_start_tick) * 32'(period_ms);
          if (interval == 0) begin
            bpm = 32'(BPM_MAX);
          end else begin
            bpm = 32'(BPM_NUMERATOR) / interval;
            if (bpm > 32'(BPM_MAX)) bpm = 32'(BPM_MAX);
            if (bpm < 32'(BPM_MIN)) bpm = 32'(BPM_MIN);
          end
          b.bpm = BPM_W'(bpm);
          b.interval = INTERVAL_W'(interval);
          produced = 1'b1;
        end
      end
    end
    ticks = ticks + 1'b1;
    return produced;
  endfunction

  function automatic int pick_gap();
    int r;
    if (!gaps_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [SAMPLE_W-1:0] clip_sample(input int level);
    if (level < 0) return '0;
    if (level > 4095) return '1;
    return SAMPLE_W'(level);
  endfunction

  task automatic log_mismatch(input string msg);
    error_count++;
    if (error_count <= REPORT_LIMIT) $display("ERROR at %0t: %s", $time, msg);
  endtask

  task automatic feed(input logic [SAMPLE_W-1:0] s, input bit typed, input beat_t typed_beat);
    int    gap;
    bit    produced;
    beat_t predicted;
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.sample <= s;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    samples_sent++;
    produced = track_beat(s, predicted);
    if (typed) begin
      beats_due.push_back(typed_beat);
    end else if (produced) begin
      beats_due.push_back(predicted);
    end
  endtask

  task automatic set_period(input logic [PERIOD_W-1:0] p);
    in_ch.valid <= 1'b0;
    while (beats_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_data <= p;
    @(posedge clk);
    cfg_we <= 1'b0;
    period_ms = p;
  endtask

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #TIMEOUT_NS;
    $display("simulation failed");
    $finish;
  end

  // result sink with random stalls and one long hold-off
  initial begin
    int stall;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      stall = 0;
      if (hold_off_due) begin
        hold_off_due = 1'b0;
        stall = HOLD_OFF_CYCLES;
      end else if (gaps_on && $urandom_range(0, 3) == 0) begin
        stall = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(8, 40);
      end
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    beat_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (beats_due.size() == 0) begin
        log_mismatch($sformatf("result with none expected: bpm %0d interval %0d",
                               out_ch.beats_per_minute, out_ch.beat_interval_ms));
      end else begin
        want = beats_due.pop_front();
        if (out_ch.beats_per_minute !== want.bpm) begin
          log_mismatch($sformatf("beats_per_minute expected %0d actual %0d",
                                 want.bpm, out_ch.beats_per_minute));
        end
        if (out_ch.beat_interval_ms !== want.interval) begin
          log_mismatch($sformatf("beat_interval_ms expected %0d actual %0d",
                                 want.interval, out_ch.beat_interval_ms));
        end
      end
    end
  end

  initial begin
    int phase;
    int base;
    int amp;
    int noise;
    int phase_end;
    int random_goal;
    int choice;
    int len;
    int rise_len;
    int level;
    int waited;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.sample = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (script[r]) begin
      if (script[r].kind == ROW_PERIOD) begin
        set_period(script[r].value[PERIOD_W-1:0]);
      end else begin
        for (int n = 0; n < script[r].count; n++) begin
          feed(script[r].value, script[r].typed, script[r].beat);
        end
      end
    end

    random_goal = samples_sent + RANDOM_ITEMS;
    phase = 0;
    while (samples_sent < random_goal) begin
      case (phase % 5)
        0: set_period(PERIOD_RESET);
        1: set_period(PERIOD_W'($urandom_range(1, 1000)));
        2: set_period('1);
        3: set_period('0);
        default: set_period(PERIOD_W'($urandom_range(0, 1023)));
      endcase
      gaps_on = (phase % 3 != 1);
      if (phase == 1) hold_off_due = 1'b1;
      base = $urandom_range(0, 2500);
      amp = $urandom_range(200, 4095 - base);
      noise = $urandom_range(0, amp / 8);
      phase_end = samples_sent + PHASE_ITEMS;
      while (samples_sent < phase_end && samples_sent < random_goal) begin
        choice = $urandom_range(0, 9);
        if (choice < 8) begin
          // one pulse: fast upstroke, slow decay
          len = $urandom_range(4, 40);
          rise_len = len / 4;
          for (int k = 0; k < len; k++) begin
            if (k < rise_len) begin
              level = base + amp * (k + 1) / rise_len;
            end else begin
              level = base + amp - amp * (k - rise_len + 1) / (len - rise_len);
            end
            level = level + $urandom_range(0, noise);
            feed(clip_sample(level), 1'b0, '0);
          end
        end else if (choice == 8) begin
          len = $urandom_range(1, 8);
          for (int k = 0; k < len; k++) begin
            feed(SAMPLE_W'($urandom_range(0, 4095)), 1'b0, '0);
          end
        end else begin
          // flat stretch with a lone artifact spike
          len = $urandom_range(1, 30);
          for (int k = 0; k < len; k++) begin
            feed(clip_sample((k == len / 2) ? 4095 : base), 1'b0, '0);
          end
        end
      end
      phase++;
    end

    in_ch.valid <= 1'b0;
    waited = 0;
    while (beats_due.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (beats_due.size() != 0) begin
      log_mismatch($sformatf("%0d expected results never arrived", beats_due.size()));
    end
    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/prd_pkg.sv
rtl/prd_if.sv
rtl/prd_ram.sv
rtl/prd_div.sv
rtl/pulse_rate_detector.sv
tb/pulse_rate_detector_test.sv
